// ===== src/tlic_pkg.sv =====
// Shared types and constants for the two-level inclusive cache tag block
package tlic_pkg;
  localparam int L1_SET_BITS = 4;
  localparam int L1_WAYS = 2;
  localparam int L2_WAY_FACTOR = 4;
  localparam int STAMP_BITS = 32;
  localparam int ADDR_BITS = 48;
  localparam int L2_SET_BITS = L1_SET_BITS + 1;
  localparam int L2_WAYS = L1_WAYS * L2_WAY_FACTOR;
  localparam int L1_SETS = 1 << L1_SET_BITS;
  localparam int L2_SETS = 1 << L2_SET_BITS;
  localparam int L1_TAG_BITS = ADDR_BITS - L1_SET_BITS;
  localparam int L2_TAG_BITS = ADDR_BITS - L2_SET_BITS;
  localparam int L1_WAY_BITS = (L1_WAYS > 1) ? $clog2(L1_WAYS) : 1;
  localparam int L2_WAY_BITS = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;

  localparam logic [1:0] L2R_NONE = 2'd0;
  localparam logic [1:0] L2R_HIT = 2'd1;
  localparam logic [1:0] L2R_MISS = 2'd2;

  localparam logic POLICY_LRU = 1'b0;

  typedef struct packed {
    logic [ADDR_BITS-1:0] address;
    logic mode;
  } in_beat_t;

  typedef struct packed {
    logic l1_hit;
    logic [1:0] l1_evictions;
    logic l2_written;
    logic [1:0] l2_result;
    logic l2_evicted;
    logic mem_written;
  } out_beat_t;

  typedef struct packed {
    logic valid;
    logic dirty;
    logic [L1_TAG_BITS-1:0] tag;
    logic [STAMP_BITS-1:0] stamp;
  } l1_line_t;

  typedef struct packed {
    logic valid;
    logic dirty;
    logic [L2_TAG_BITS-1:0] tag;
    logic [STAMP_BITS-1:0] stamp;
  } l2_line_t;

  typedef l1_line_t [L1_WAYS-1:0] l1_row_t;
  typedef l2_line_t [L2_WAYS-1:0] l2_row_t;
endpackage

// ===== src/two_level_inclusive_cache_tags_core.sv =====
// Top level: sequencer over the L1 and L2 tag memories
// Sequence: R1, L1, then WB on an L1 hit, R2 and L2 on a clean L1 miss, or
// WBR, WB, R2 and L2 on a dirty L1 victim; DONE shows the result with out_valid,
// and busy holds until the return to IDLE. A new access starts only after the
// read-modify-write of the L1 row and then of up to two L2 rows in one L2 RAM.
// Reset: a clearing pass walks all 32 L2 rows (busy high); L1 rows are masked
// invalid by per-set flip-flops, and the pointers are flip-flops reset at once.
module two_level_inclusive_cache_tags_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_start,
  output logic                in_busy,
  input  tlic_pkg::in_beat_t  in_data,
  output logic                out_valid,
  output tlic_pkg::out_beat_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  localparam int L1W = tlic_pkg::L1_WAYS;
  localparam int L2W = tlic_pkg::L2_WAYS;
  localparam int S1B = tlic_pkg::L1_SET_BITS;
  localparam int S2B = tlic_pkg::L2_SET_BITS;
  localparam int T1B = tlic_pkg::L1_TAG_BITS;
  localparam int T2B = tlic_pkg::L2_TAG_BITS;
  localparam int SB = tlic_pkg::STAMP_BITS;
  localparam int W1B = tlic_pkg::L1_WAY_BITS;
  localparam int W2B = tlic_pkg::L2_WAY_BITS;
  localparam int AB = tlic_pkg::ADDR_BITS;
  localparam int L1RW = $bits(tlic_pkg::l1_row_t);
  localparam int L2RW = $bits(tlic_pkg::l2_row_t);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_R1    = 4'd2;
  localparam logic [3:0] ST_L1    = 4'd3;
  localparam logic [3:0] ST_WBR   = 4'd4;
  localparam logic [3:0] ST_WB    = 4'd5;
  localparam logic [3:0] ST_R2    = 4'd6;
  localparam logic [3:0] ST_L2    = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  logic       policy;
  logic [4:0] block_bits;

  tlic_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(cfg_psel), .penable(cfg_penable),
    .pwrite(cfg_pwrite), .paddr(cfg_paddr), .pwdata(cfg_pwdata),
    .prdata(cfg_prdata), .pready(cfg_pready), .policy(policy),
    .block_bits(block_bits)
  );

  logic [3:0] state_r, state_nxt;
  logic [AB-1:0] addr_r;
  logic mode_r;
  tlic_pkg::out_beat_t res_r, res_nxt;
  logic [SB-1:0] nclk_r, nclk_nxt, fclk_r, fclk_nxt;
  logic [L1W-1:0] nptr_r [tlic_pkg::L1_SETS];
  logic [L2W-1:0] fptr_r [tlic_pkg::L2_SETS];
  logic [tlic_pkg::L1_SETS-1:0] l1ok_r;
  logic [S2B-1:0] clr_r;

  // derived address fields
  logic [AB-1:0] line_w, t1_full, t2_full;
  logic [S1B-1:0] s1;
  logic [S2B-1:0] s2;
  logic [T1B-1:0] t1;
  logic [T2B-1:0] t2;
  assign line_w  = addr_r >> block_bits;
  assign t1_full = line_w >> S1B;
  assign t2_full = line_w >> S2B;
  assign s1 = line_w[S1B-1:0];
  assign s2 = line_w[S2B-1:0];
  assign t1 = t1_full[T1B-1:0];
  assign t2 = t2_full[T2B-1:0];

  // memories
  logic l1_we;
  logic [L1RW-1:0] l1_wd, l1_rd;
  logic l2_we;
  logic [S2B-1:0] l2_wa, l2_ra;
  logic [L2RW-1:0] l2_wd, l2_rd;

  tlic_ram #(.WIDTH(L1RW), .DEPTH(tlic_pkg::L1_SETS)) u_l1 (
    .clk(clk), .we(l1_we), .waddr(s1), .wdata(l1_wd), .raddr(s1), .rdata(l1_rd)
  );
  tlic_ram #(.WIDTH(L2RW), .DEPTH(tlic_pkg::L2_SETS)) u_l2 (
    .clk(clk), .we(l2_we), .waddr(l2_wa), .wdata(l2_wd), .raddr(l2_ra),
    .rdata(l2_rd)
  );

  tlic_pkg::l1_row_t row1_r, row1_nxt, row1_in;
  // write-back request: tag of dirty L1 victim, or of the L1 hit line for the touch
  logic wb_r, wb_nxt;
  logic [T1B-1:0] wbtag_r, wbtag_nxt;
  logic [S2B-1:0] wbset;
  assign wbset = {wbtag_r[0], s1};

  tlic_pkg::l2_row_t row2_in, row2_o;
  tlic_pkg::l1_row_t row1_o;
  logic [L2W-1:0] fptr_o;
  logic hit1;

  always_comb begin
    row1_in = l1ok_r[s1] ? tlic_pkg::l1_row_t'(l1_rd) : '0;
    row2_in = tlic_pkg::l2_row_t'(l2_rd);
  end

  // L1 step: hit check, victim choice, fill
  logic [W1B-1:0] hw1, vw1;
  logic free1, any1;
  always_comb begin
    hit1 = 1'b0; hw1 = '0; free1 = 1'b0; vw1 = '0; any1 = 1'b0;
    for (int w = L1W - 1; w >= 0; w--) begin
      if (row1_in[w].valid && row1_in[w].tag == t1) begin
        hit1 = 1'b1; hw1 = W1B'(w);
      end
    end
    for (int w = L1W - 1; w >= 0; w--) begin
      if (!row1_in[w].valid) begin
        free1 = 1'b1; vw1 = W1B'(w);
      end
    end
    if (!free1) begin
      if (policy == tlic_pkg::POLICY_LRU) begin
        vw1 = '0;
        for (int w = 1; w < L1W; w++)
          if (row1_in[w].stamp < row1_in[vw1].stamp) vw1 = W1B'(w);
      end else begin
        for (int w = 0; w < L1W; w++)
          if (nptr_r[s1][w]) vw1 = W1B'(w);
      end
    end
    any1 = !free1;
  end

  // L2 row logic shared by touch and lookup
  logic [W2B-1:0] hw2, vw2;
  logic hit2, free2;
  logic [T2B-1:0] ltag;
  logic [S2B-1:0] lset;
  always_comb begin
    if (state_r == ST_WB) begin
      ltag = T2B'(wbtag_r >> 1);
      lset = wbset;
    end else if (state_r == ST_L2) begin
      ltag = t2;
      lset = s2;
    end else begin
      ltag = T2B'(t1 >> 1);
      lset = {t1[0], s1};
    end
    hit2 = 1'b0; hw2 = '0; free2 = 1'b0; vw2 = '0;
    for (int w = L2W - 1; w >= 0; w--) begin
      if (row2_in[w].valid && row2_in[w].tag == ltag) begin
        hit2 = 1'b1; hw2 = W2B'(w);
      end
    end
    for (int w = L2W - 1; w >= 0; w--) begin
      if (!row2_in[w].valid) begin
        free2 = 1'b1; vw2 = W2B'(w);
      end
    end
    if (!free2) begin
      if (policy == tlic_pkg::POLICY_LRU) begin
        vw2 = '0;
        for (int w = 1; w < L2W; w++)
          if (row2_in[w].stamp < row2_in[vw2].stamp) vw2 = W2B'(w);
      end else begin
        for (int w = 0; w < L2W; w++)
          if (fptr_r[lset][w]) vw2 = W2B'(w);
      end
    end
  end

  logic [T1B-1:0] back;
  logic bmatch;
  logic [W1B-1:0] bw;
  always_comb begin
    back = {row2_in[vw2].tag, s2[S2B-1]};
    bmatch = 1'b0; bw = '0;
    for (int j = L1W - 1; j >= 0; j--) begin
      if (row1_r[j].valid && row1_r[j].tag == back) begin
        bmatch = 1'b1; bw = W1B'(j);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    res_nxt = res_r;
    nclk_nxt = nclk_r;
    fclk_nxt = fclk_r;
    row1_nxt = row1_r;
    wb_nxt = wb_r;
    wbtag_nxt = wbtag_r;
    l1_we = 1'b0;
    l1_wd = row1_r;
    l2_we = 1'b0;
    l2_wa = lset;
    l2_wd = row2_in;
    l2_ra = {t1[0], s1};
    row2_o = row2_in;
    row1_o = row1_in;
    fptr_o = fptr_r[lset];
    unique case (state_r)
      ST_CLEAR: begin
        l2_we = 1'b1;
        l2_wa = clr_r;
        l2_wd = '0;
        if (clr_r == S2B'(tlic_pkg::L2_SETS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_start) state_nxt = ST_R1;
      end
      ST_R1: begin
        state_nxt = ST_L1;
      end
      ST_L1: begin
        res_nxt = '0;
        wb_nxt = 1'b0;
        if (hit1) begin
          res_nxt.l1_hit = 1'b1;
          row1_o[hw1].stamp = nclk_r;
          if (mode_r) row1_o[hw1].dirty = 1'b1;
          nclk_nxt = nclk_r + 1'b1;
          l1_we = 1'b1;
          l1_wd = row1_o;
          // touch L2 copy; row for {t1[0],s1} is being read now
          state_nxt = ST_WB;
          wb_nxt = 1'b0;
          wbtag_nxt = t1;
        end else begin
          if (any1) begin
            res_nxt.l1_evictions = 2'd1;
            if (row1_in[vw1].dirty) begin
              wb_nxt = 1'b1;
              wbtag_nxt = row1_in[vw1].tag;
              res_nxt.l2_written = 1'b1;
            end
          end
          row1_o[vw1].valid = 1'b1;
          row1_o[vw1].tag = t1;
          row1_o[vw1].stamp = nclk_r;
          row1_o[vw1].dirty = mode_r;
          nclk_nxt = nclk_r + 1'b1;
          row1_nxt = row1_o;
          state_nxt = (any1 && row1_in[vw1].dirty) ? ST_WBR : ST_R2;
        end
      end
      ST_WBR: begin
        l2_ra = wbset;
        state_nxt = ST_WB;
      end
      ST_WB: begin
        // touch: refresh stamp, dirty for write-back
        fclk_nxt = fclk_r + 1'b1;
        if (hit2) begin
          row2_o[hw2].stamp = fclk_r;
          if (wb_r) row2_o[hw2].dirty = 1'b1;
          l2_we = 1'b1;
          l2_wd = row2_o;
        end
        if (res_r.l1_hit) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_R2;
        end
      end
      ST_R2: begin
        l2_ra = s2;
        state_nxt = ST_L2;
      end
      ST_L2: begin
        state_nxt = ST_DONE;
        l2_we = 1'b1;
        l1_we = 1'b1;
        l1_wd = row1_r;
        fclk_nxt = fclk_r + 1'b1;
        if (hit2) begin
          res_nxt.l2_result = tlic_pkg::L2R_HIT;
          row2_o[hw2].stamp = fclk_r;
        end else begin
          res_nxt.l2_result = tlic_pkg::L2R_MISS;
          if (!free2) begin
            res_nxt.l2_evicted = 1'b1;
            if (bmatch) begin
              row1_o = row1_r;
              row1_o[bw].valid = 1'b0;
              row1_o[bw].dirty = 1'b0;
              l1_wd = row1_o;
              res_nxt.l1_evictions = res_r.l1_evictions + 2'd1;
              if (row1_r[bw].dirty) res_nxt.mem_written = 1'b1;
            end
            if (row2_in[vw2].dirty && !(bmatch && row1_r[bw].dirty))
              res_nxt.mem_written = 1'b1;
            if (row2_in[vw2].dirty) res_nxt.mem_written = 1'b1;
          end
          row2_o[vw2].valid = 1'b1;
          row2_o[vw2].tag = t2;
          row2_o[vw2].dirty = 1'b0;
          row2_o[vw2].stamp = fclk_r;
          fptr_o = {fptr_r[lset][L2W-2:0], fptr_r[lset][L2W-1]};
        end
        l2_wd = row2_o;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (state_r == ST_R1 || state_r == ST_L1 && hit1) l2_ra = {t1[0], s1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      nclk_r <= SB'(1);
      fclk_r <= SB'(1);
      l1ok_r <= '0;
      for (int i = 0; i < tlic_pkg::L1_SETS; i++) nptr_r[i] <= L1W'(1);
      for (int i = 0; i < tlic_pkg::L2_SETS; i++) fptr_r[i] <= L2W'(1);
      res_r <= '0;
      wb_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_r + 1'b1;
      nclk_r <= nclk_nxt;
      fclk_r <= fclk_nxt;
      res_r <= res_nxt;
      wb_r <= wb_nxt;
      if (l1_we) l1ok_r[s1] <= 1'b1;
      if (state_r == ST_L1 && !hit1)
        nptr_r[s1] <= {nptr_r[s1][L1W-2:0], nptr_r[s1][L1W-1]};
      if (state_r == ST_L2) fptr_r[lset] <= fptr_o;
    end
  end

  always_ff @(posedge clk) begin
    row1_r <= row1_nxt;
    wbtag_r <= wbtag_nxt;
    if (state_r == ST_IDLE && in_start) begin
      addr_r <= in_data.address;
      mode_r <= in_data.mode;
    end
  end

  assign in_busy = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);
  assign out_data = res_r;
endmodule

// ===== src/tlic_cfg.sv =====
// APB configuration registers: policy and block offset bits
module tlic_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        policy,
  output logic [4:0]  block_bits
);
  localparam logic [2:0] REG_POLICY = 3'd0;
  localparam logic [2:0] REG_BLOCK = 3'd4;

  logic       policy_r;
  logic [4:0] block_r;

  assign pready = 1'b1;
  assign policy = policy_r;
  assign block_bits = block_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= 1'b0;
      block_r  <= 5'd4;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        REG_POLICY: policy_r <= pwdata[0];
        REG_BLOCK:  block_r  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      REG_POLICY: prdata = {31'd0, policy_r};
      REG_BLOCK:  prdata = {27'd0, block_r};
      default:    prdata = 32'd0;
    endcase
  end
endmodule

// ===== src/tlic_ram.sv =====
// Generic synchronous RAM, one write and one registered read port
module tlic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== test/tb_top.sv =====
// Testbench for the two-level inclusive cache tag block: random and directed accesses
`timescale 1ns / 100ps

class cache_scoreboard;
  bit n_valid [tlic_pkg::L1_SETS][tlic_pkg::L1_WAYS];
  bit n_dirty [tlic_pkg::L1_SETS][tlic_pkg::L1_WAYS];
  logic [47:0] n_tag [tlic_pkg::L1_SETS][tlic_pkg::L1_WAYS];
  logic [31:0] n_stamp [tlic_pkg::L1_SETS][tlic_pkg::L1_WAYS];
  bit f_valid [tlic_pkg::L2_SETS][tlic_pkg::L2_WAYS];
  bit f_dirty [tlic_pkg::L2_SETS][tlic_pkg::L2_WAYS];
  logic [47:0] f_tag [tlic_pkg::L2_SETS][tlic_pkg::L2_WAYS];
  logic [31:0] f_stamp [tlic_pkg::L2_SETS][tlic_pkg::L2_WAYS];
  int n_ptr [tlic_pkg::L1_SETS];
  int f_ptr [tlic_pkg::L2_SETS];
  logic [31:0] n_clk, f_clk;
  bit fifo_mode;
  int unsigned blk;
  tlic_pkg::out_beat_t pending[$];
  int errors;

  function new();
    n_clk = 1;
    f_clk = 1;
    blk = 4;
    for (int s = 0; s < tlic_pkg::L1_SETS; s++) begin
      n_ptr[s] = 0;
      for (int w = 0; w < tlic_pkg::L1_WAYS; w++) begin
        n_valid[s][w] = 0; n_dirty[s][w] = 0; n_tag[s][w] = 0; n_stamp[s][w] = 0;
      end
    end
    for (int s = 0; s < tlic_pkg::L2_SETS; s++) begin
      f_ptr[s] = 0;
      for (int w = 0; w < tlic_pkg::L2_WAYS; w++) begin
        f_valid[s][w] = 0; f_dirty[s][w] = 0; f_tag[s][w] = 0; f_stamp[s][w] = 0;
      end
    end
  endfunction

  function void touch_far(int s1, logic [47:0] t1, bit mk_dirty);
    int fs;
    logic [31:0] st;
    fs = ((int'(t1[0]) << tlic_pkg::L1_SET_BITS) | s1) & (tlic_pkg::L2_SETS - 1);
    st = f_clk;
    f_clk = f_clk + 1;
    for (int w = 0; w < tlic_pkg::L2_WAYS; w++)
      if (f_valid[fs][w] && f_tag[fs][w] == (t1 >> 1)) begin
        f_stamp[fs][w] = st;
        if (mk_dirty) f_dirty[fs][w] = 1;
        break;
      end
  endfunction

  function void note_access(tlic_pkg::in_beat_t it);
    tlic_pkg::out_beat_t r;
    logic [47:0] ln, t1, t2, back;
    int s1, s2, w, v, evs;
    bit hit, freew;
    r = '0;
    ln = it.address >> blk;
    s1 = int'(ln[tlic_pkg::L1_SET_BITS-1:0]);
    s2 = int'(ln[tlic_pkg::L2_SET_BITS-1:0]);
    t1 = it.address >> (blk + tlic_pkg::L1_SET_BITS);
    t2 = it.address >> (blk + tlic_pkg::L1_SET_BITS + 1);
    hit = 0;
    evs = 0;
    for (w = 0; w < tlic_pkg::L1_WAYS; w++)
      if (n_valid[s1][w] && n_tag[s1][w] == t1) begin hit = 1; break; end
    if (hit) begin
      r.l1_hit = 1;
      n_stamp[s1][w] = n_clk; n_clk = n_clk + 1;
      touch_far(s1, t1, 0);
      if (it.mode) n_dirty[s1][w] = 1;
      r.l2_result = tlic_pkg::L2R_NONE;
    end else begin
      freew = 0;
      for (v = 0; v < tlic_pkg::L1_WAYS; v++)
        if (!n_valid[s1][v]) begin freew = 1; break; end
      if (!freew) begin
        evs++;
        if (fifo_mode == tlic_pkg::POLICY_LRU) begin
          v = 0;
          for (w = 1; w < tlic_pkg::L1_WAYS; w++)
            if (n_stamp[s1][w] < n_stamp[s1][v]) v = w;
        end else v = n_ptr[s1] % tlic_pkg::L1_WAYS;
        if (n_dirty[s1][v]) begin
          touch_far(s1, n_tag[s1][v], 1);
          n_dirty[s1][v] = 0;
          r.l2_written = 1;
        end
      end
      n_valid[s1][v] = 1; n_tag[s1][v] = t1;
      n_stamp[s1][v] = n_clk; n_clk = n_clk + 1;
      n_ptr[s1] = (n_ptr[s1] + 1) % tlic_pkg::L1_WAYS;
      n_dirty[s1][v] = it.mode;
      hit = 0;
      for (w = 0; w < tlic_pkg::L2_WAYS; w++)
        if (f_valid[s2][w] && f_tag[s2][w] == t2) begin hit = 1; break; end
      if (hit) begin
        r.l2_result = tlic_pkg::L2R_HIT;
        f_stamp[s2][w] = f_clk; f_clk = f_clk + 1;
      end else begin
        r.l2_result = tlic_pkg::L2R_MISS;
        freew = 0;
        for (v = 0; v < tlic_pkg::L2_WAYS; v++)
          if (!f_valid[s2][v]) begin freew = 1; break; end
        if (!freew) begin
          r.l2_evicted = 1;
          if (fifo_mode == tlic_pkg::POLICY_LRU) begin
            v = 0;
            for (w = 1; w < tlic_pkg::L2_WAYS; w++)
              if (f_stamp[s2][w] < f_stamp[s2][v]) v = w;
          end else v = f_ptr[s2] % tlic_pkg::L2_WAYS;
          back = (f_tag[s2][v] << 1) | ((s2 >> tlic_pkg::L1_SET_BITS) & 1);
          for (int j = 0; j < tlic_pkg::L1_WAYS; j++)
            if (n_valid[s1][j] && n_tag[s1][j] == back) begin
              n_valid[s1][j] = 0; f_valid[s2][v] = 0; evs++;
              if (n_dirty[s1][j]) begin
                n_dirty[s1][j] = 0; f_dirty[s2][v] = 0; r.mem_written = 1;
              end
              break;
            end
          if (f_dirty[s2][v]) begin r.mem_written = 1; f_dirty[s2][v] = 0; end
        end
        f_valid[s2][v] = 1; f_tag[s2][v] = t2; f_dirty[s2][v] = 0;
        f_stamp[s2][v] = f_clk; f_clk = f_clk + 1;
        f_ptr[s2] = (f_ptr[s2] + 1) % tlic_pkg::L2_WAYS;
      end
    end
    r.l1_evictions = evs[1:0];
    pending.push_back(r);
  endfunction

  function void check_report(tlic_pkg::out_beat_t got);
    tlic_pkg::out_beat_t e;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected report %p", got);
      return;
    end
    e = pending.pop_front();
    if (got.l1_hit !== e.l1_hit || got.l1_evictions !== e.l1_evictions ||
        got.l2_written !== e.l2_written || got.l2_result !== e.l2_result ||
        got.l2_evicted !== e.l2_evicted || got.mem_written !== e.mem_written) begin
      errors++;
      if (errors <= 10) $display("mismatch: expected %p got %p", e, got);
    end
  endfunction
endclass

module tb_top;
  localparam int REG_POLICY = 0;
  localparam int REG_BLOCK_BITS = 1;
  localparam int WATCHDOG = 20000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_start = 0;
  logic in_busy;
  tlic_pkg::in_beat_t in_data = '0;
  logic out_valid;
  tlic_pkg::out_beat_t out_data;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;
  int idle_cycles = 0;
  cache_scoreboard sb = new();
  logic [47:0] hot [8];

  always #4 clk = ~clk;

  two_level_inclusive_cache_tags_core dut (.*);

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_report(out_data);
    if ((in_start && !in_busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(5, 30));
    return int'($urandom_range(0, 2));
  endfunction

  task automatic send_access(logic [47:0] a, logic m, bit stall);
    tlic_pkg::in_beat_t it;
    int n;
    it.address = a;
    it.mode = m;
    in_start <= 1;
    in_data <= it;
    @(posedge clk);
    while (in_busy) @(posedge clk);
    sb.note_access(it);
    n = stall ? gap_len() : 0;
    if (n > 0) begin
      in_start <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic write_reg(int idx, logic [31:0] val);
    in_start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= 3'(idx * 4); cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    if (idx == REG_POLICY) sb.fifo_mode = val[0];
    else sb.blk = val[4:0];
    @(posedge clk);
  endtask

  task automatic random_phase(int count);
    logic [47:0] a;
    bit stall;
    for (int k = 0; k < 8; k++) hot[k] = 48'({$urandom, $urandom});
    stall = 1;
    for (int k = 0; k < count; k++) begin
      if (k % 60 == 0) stall = $urandom_range(0, 2) != 0;
      case ($urandom_range(0, 3))
        0: a = 48'({$urandom, $urandom});
        default: begin
          a = hot[$urandom_range(0, 7)];
          a = a ^ (48'($urandom_range(0, 63)) << (sb.blk + 4));
          a = a ^ 48'($urandom_range(0, 511));
        end
      endcase
      send_access(a, 1'($urandom_range(0, 1)), stall);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_access('0, 1'b0, 1'b0);
    send_access('1, 1'b1, 1'b0);
    send_access('0, 1'b1, 1'b1);
    send_access('0, 1'b0, 1'b0);
    for (int k = 0; k < 12; k++) send_access(48'(k) << 8, k[0], 1'b0);
    for (int k = 0; k < 6; k++) send_access(48'(k) << 8, 1'b0, 1'b1);
    random_phase(180);
    write_reg(REG_POLICY, 1);
    random_phase(180);
    write_reg(REG_BLOCK_BITS, 0);
    random_phase(150);
    write_reg(REG_BLOCK_BITS, 31);
    random_phase(80);
    write_reg(REG_BLOCK_BITS, 16);
    write_reg(REG_POLICY, 0);
    random_phase(150);
    write_reg(REG_BLOCK_BITS, 1);
    random_phase(188);
    in_start <= 0;
    begin : drain
      int lim;
      lim = 0;
      while (sb.pending.size() != 0 && lim < WATCHDOG) begin
        @(posedge clk);
        lim++;
      end
      repeat (20) @(posedge clk);
    end
    if (sb.errors == 0 && sb.pending.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
